// ===== hdl/ttps_pkg.sv =====
`default_nettype none

package ttps_pkg;

  // Table geometry: 2^INDEX_BITS direct-mapped entries.
  localparam int INDEX_BITS  = 16;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int KEY_BITS    = 64;

  // Command queue between the front and back parts (power of two).
  localparam int QPTR_BITS   = 1;
  localparam int QUEUE_DEPTH = 1 << QPTR_BITS;

  // Score constants.
  localparam logic signed [15:0] MATE_BOUND = 16'sd9500;
  localparam logic signed [15:0] MATE_NEG   = -16'sd9500;
  localparam logic signed [15:0] NO_SCORE   = 16'sd11000;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_NONE  = 2'd3
  } bound_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_RUN,
    S_READ
  } back_state_t;

  // Entry layout, LSB first: from, dest, kind, value, bound, depth.
  typedef struct packed {
    logic [7:0]         depth;
    logic [1:0]         bound;
    logic signed [15:0] value;
    logic [3:0]         mv_kind;
    logic [5:0]         mv_dest;
    logic [5:0]         mv_from;
  } entry_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    entry_t              entry;
  } mem_word_t;

  // Classified item as it travels through the queue.
  typedef struct packed {
    logic [1:0]          op;
    logic [KEY_BITS-1:0] key;
    logic [7:0]          depth;
    logic [7:0]          ply;
    logic signed [15:0]  alpha;
    logic signed [15:0]  beta;
    entry_t              entry;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ttps_front.sv =====
`default_nettype none

module ttps_front import ttps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          op,
  input  logic [KEY_BITS-1:0] position_key,
  input  logic [7:0]          search_depth,
  input  logic [7:0]          ply,
  input  logic signed [15:0]  alpha,
  input  logic signed [15:0]  beta,
  input  logic signed [15:0]  store_value,
  input  logic [1:0]          bound_kind,
  input  logic [5:0]          move_from,
  input  logic [5:0]          move_dest,
  input  logic [3:0]          move_kind,
  output cmd_t                cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready
);

  cmd_t               cmd_next;
  logic signed [16:0] sval_wide;
  logic signed [16:0] ply_wide;

  assign ply_wide = $signed({9'd0, ply});

  // Mate scores are pushed away from zero on store; wraps to 16 bits.
  always_comb begin
    sval_wide = {store_value[15], store_value};
    if (store_value >= MATE_BOUND) begin
      sval_wide = {store_value[15], store_value} + ply_wide;
    end else if (store_value <= MATE_NEG) begin
      sval_wide = {store_value[15], store_value} - ply_wide;
    end
  end

  always_comb begin
    cmd_next               = '0;
    cmd_next.op            = op;
    cmd_next.key           = position_key;
    cmd_next.depth         = search_depth;
    cmd_next.ply           = ply;
    cmd_next.alpha         = alpha;
    cmd_next.beta          = beta;
    cmd_next.entry.depth   = search_depth;
    cmd_next.entry.bound   = bound_kind;
    cmd_next.entry.value   = sval_wide[15:0];
    cmd_next.entry.mv_kind = move_kind;
    cmd_next.entry.mv_dest = move_dest;
    cmd_next.entry.mv_from = move_from;
  end

  assign item_ready = !rst && (!cmd_valid || cmd_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (item_ready) begin
      cmd_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ttps_queue.sv =====
`default_nettype none

module ttps_queue import ttps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t in_cmd,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t out_cmd,
  output logic out_valid,
  input  logic out_ready
);

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 pop;

  assign in_ready  = count != (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ttps_back.sv =====
`default_nettype none

module ttps_back import ttps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [15:0] value,
  output logic               cutoff,
  output logic               move_hit,
  output logic [5:0]         hint_from,
  output logic [5:0]         hint_dest,
  output logic [3:0]         hint_kind
);

  mem_word_t table_mem [0:TABLE_DEPTH-1];
  mem_word_t rdata;
  mem_word_t wdata;
  logic [INDEX_BITS-1:0] waddr;
  logic [INDEX_BITS-1:0] raddr;
  logic                  we;
  logic                  re;

  back_state_t           state;
  back_state_t           state_next;
  logic [INDEX_BITS-1:0] clear_index;
  logic [INDEX_BITS-1:0] clear_index_next;

  // Probe arguments held while the entry is read.
  logic [KEY_BITS-1:0] p_key;
  logic [7:0]          p_depth;
  logic [7:0]          p_ply;
  logic signed [15:0]  p_alpha;
  logic signed [15:0]  p_beta;
  logic                capture;

  logic               slot_free;
  logic               load;
  logic signed [15:0] value_next;
  logic               cutoff_next;
  logic               move_hit_next;
  logic [5:0]         hint_from_next;
  logic [5:0]         hint_dest_next;
  logic [3:0]         hint_kind_next;

  logic signed [16:0] v_wide;
  logic signed [16:0] ply_wide;
  logic signed [15:0] v_adj;
  logic               tag_hit;
  logic               deep;
  logic               cut;

  assign slot_free = !result_valid || result_ready;
  assign ply_wide  = $signed({9'd0, p_ply});

  // Mate scores move toward zero on probe.
  always_comb begin
    v_wide = {rdata.entry.value[15], rdata.entry.value};
    if (rdata.entry.value >= MATE_BOUND) begin
      v_wide = {rdata.entry.value[15], rdata.entry.value} - ply_wide;
    end else if (rdata.entry.value <= MATE_NEG) begin
      v_wide = {rdata.entry.value[15], rdata.entry.value} + ply_wide;
    end
  end

  assign v_adj   = v_wide[15:0];
  assign tag_hit = rdata.key == p_key;
  assign deep    = rdata.entry.depth >= p_depth;

  always_comb begin
    case (rdata.entry.bound)
      BOUND_EXACT: cut = 1'b1;
      BOUND_UPPER: cut = v_adj <= p_alpha;
      BOUND_LOWER: cut = v_adj >= p_beta;
      default:     cut = 1'b0;
    endcase
    cut = cut && tag_hit && deep;
  end

  always_comb begin
    state_next       = state;
    clear_index_next = clear_index;
    we               = 1'b0;
    waddr            = cmd.key[INDEX_BITS-1:0];
    wdata            = '{key: cmd.key, entry: cmd.entry};
    re               = 1'b0;
    raddr            = cmd.key[INDEX_BITS-1:0];
    cmd_ready        = 1'b0;
    capture          = 1'b0;
    load             = 1'b0;
    value_next       = '0;
    cutoff_next      = 1'b0;
    move_hit_next    = 1'b0;
    hint_from_next   = '0;
    hint_dest_next   = '0;
    hint_kind_next   = '0;
    case (state)
      S_CLEAR: begin
        we               = 1'b1;
        waddr            = clear_index;
        wdata            = '0;
        clear_index_next = clear_index + 1'b1;
        if (clear_index == '1) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd_valid && slot_free) begin
          cmd_ready = 1'b1;
          case (cmd.op)
            OP_PROBE: begin
              re         = 1'b1;
              capture    = 1'b1;
              state_next = S_READ;
            end
            OP_STORE: begin
              we   = 1'b1;
              load = 1'b1;
            end
            OP_CLEAR: begin
              load       = 1'b1;
              state_next = S_CLEAR;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        load          = 1'b1;
        cutoff_next   = cut;
        move_hit_next = tag_hit && !cut;
        value_next    = cut ? v_adj : NO_SCORE;
        if (tag_hit && !cut) begin
          hint_from_next = rdata.entry.mv_from;
          hint_dest_next = rdata.entry.mv_dest;
          hint_kind_next = rdata.entry.mv_kind;
        end
        state_next = S_RUN;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clear_index <= '0;
    end else begin
      state       <= state_next;
      clear_index <= clear_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= table_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      p_key   <= cmd.key;
      p_depth <= cmd.depth;
      p_ply   <= cmd.ply;
      p_alpha <= cmd.alpha;
      p_beta  <= cmd.beta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value     <= value_next;
      cutoff    <= cutoff_next;
      move_hit  <= move_hit_next;
      hint_from <= hint_from_next;
      hint_dest <= hint_dest_next;
      hint_kind <= hint_kind_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/transposition_table_probe_store.sv =====
`default_nettype none

// Direct-mapped transposition table, 2^INDEX_BITS entries (65536 as built),
// indexed by the low key bits and tagged with the whole 64-bit key. Every
// beat in gives exactly one result beat: a probe reports a cutoff score,
// or else the no-score value, with the stored move hint if the tag matched;
// store, clear and undefined ops answer all zeros. A front stage classifies
// each beat and pre-adjusts store scores, a two-entry queue decouples it
// from the back end, and the back end owns the single-port table memory.
// At the back end a store writes the table, a probe does a registered
// memory read and then a compare into the output register, and a clear
// zeroes one entry per cycle across the whole table. After reset the same
// clearing pass zeroes every entry before the first queued beat is served;
// the front still fills the queue meanwhile. While a result waits on
// result_ready the back end holds off its next beat, taking it at the edge
// where the result leaves; the front register and the queue still take up
// to three more beats before item_ready drops.

module transposition_table_probe_store import ttps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [1:0]          op,
  input  logic [KEY_BITS-1:0] position_key,
  input  logic [7:0]          search_depth,
  input  logic [7:0]          ply,
  input  logic signed [15:0]  alpha,
  input  logic signed [15:0]  beta,
  input  logic signed [15:0]  store_value,
  input  logic [1:0]          bound_kind,
  input  logic [5:0]          move_from,
  input  logic [5:0]          move_dest,
  input  logic [3:0]          move_kind,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [15:0]  value,
  output logic                cutoff,
  output logic                move_hit,
  output logic [5:0]          hint_from,
  output logic [5:0]          hint_dest,
  output logic [3:0]          hint_kind
);

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // Front: classify and adjust store scores.
  ttps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .position_key (position_key),
    .search_depth (search_depth),
    .ply          (ply),
    .alpha        (alpha),
    .beta         (beta),
    .store_value  (store_value),
    .bound_kind   (bound_kind),
    .move_from    (move_from),
    .move_dest    (move_dest),
    .move_kind    (move_kind),
    .cmd          (front_cmd),
    .cmd_valid    (front_valid),
    .cmd_ready    (front_ready)
  );

  // Queue: lets the front keep taking beats during a clear sweep.
  ttps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (front_cmd),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_cmd   (back_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  // Back: table memory, clear sweep, probe evaluation, result register.
  ttps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (back_cmd),
    .cmd_valid    (back_valid),
    .cmd_ready    (back_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value        (value),
    .cutoff       (cutoff),
    .move_hit     (move_hit),
    .hint_from    (hint_from),
    .hint_dest    (hint_dest),
    .hint_kind    (hint_kind)
  );

  // A probe either cuts off or hands back a hint, never both.
  a_cut_or_hint : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(cutoff && move_hit))
    else $error("cutoff and move_hit both set");

  // Hint fields stay zero unless a hint is reported.
  a_hint_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && !move_hit |-> hint_from == '0 && hint_dest == '0 && hint_kind == '0)
    else $error("hint fields nonzero without move_hit");

  // Without a cutoff the score is either the no-score marker or zero.
  a_no_cut_value : assert property (@(posedge clk) disable iff (rst)
    result_valid && !cutoff |-> value == NO_SCORE || value == '0)
    else $error("unexpected value without cutoff");

endmodule

`default_nettype wire

// ===== dv/transposition_table_probe_store_checker.sv =====
`default_nettype none

// Watches both channels, keeps a shadow copy of the table and compares each
// result beat with the oldest predicted response.
module transposition_table_probe_store_checker import ttps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  logic [1:0]          op,
  input  logic [KEY_BITS-1:0] position_key,
  input  logic [7:0]          search_depth,
  input  logic [7:0]          ply,
  input  logic signed [15:0]  alpha,
  input  logic signed [15:0]  beta,
  input  logic signed [15:0]  store_value,
  input  logic [1:0]          bound_kind,
  input  logic [5:0]          move_from,
  input  logic [5:0]          move_dest,
  input  logic [3:0]          move_kind,
  input  logic                result_valid,
  input  logic                result_ready,
  input  logic signed [15:0]  value,
  input  logic                cutoff,
  input  logic                move_hit,
  input  logic [5:0]          hint_from,
  input  logic [5:0]          hint_dest,
  input  logic [3:0]          hint_kind,
  output int                  fail_count,
  output int                  outstanding
);

  typedef struct packed {
    logic signed [15:0] value;
    logic               cutoff;
    logic               move_hit;
    logic [5:0]         hint_from;
    logic [5:0]         hint_dest;
    logic [3:0]         hint_kind;
  } tt_response_t;

  // Sparse shadow table; a missing slot reads as the cleared (all zero) entry.
  logic [KEY_BITS-1:0] shadow_tags    [bit [INDEX_BITS-1:0]];
  entry_t              shadow_entries [bit [INDEX_BITS-1:0]];
  tt_response_t        expected_responses[$];
  int                  fails = 0;

  function automatic tt_response_t lookup_or_update(
    input logic [1:0]          cmd,
    input logic [KEY_BITS-1:0] key,
    input logic [7:0]          min_depth,
    input logic [7:0]          plies,
    input logic signed [15:0]  lo,
    input logic signed [15:0]  hi,
    input logic signed [15:0]  score_in,
    input logic [1:0]          bkind,
    input logic [5:0]          mfrom,
    input logic [5:0]          mdest,
    input logic [3:0]          mkind
  );
    tt_response_t             rsp;
    entry_t                   ent;
    logic [INDEX_BITS-1:0]    slot;
    logic [KEY_BITS-1:0]      tag;
    int                       score;
    logic                     usable;
    rsp   = '0;
    ent   = '0;
    tag   = '0;
    slot  = key[INDEX_BITS-1:0];
    case (cmd)
      OP_PROBE: begin
        if (shadow_entries.exists(slot)) ent = shadow_entries[slot];
        if (shadow_tags.exists(slot)) tag = shadow_tags[slot];
        // mate scores are pulled toward zero by the distance from root
        score = int'($signed(ent.value));
        if (score >= int'(MATE_BOUND)) score = score - int'(plies);
        if (score <= int'(MATE_NEG)) score = score + int'(plies);
        rsp.value = NO_SCORE;
        if (tag == key) begin
          usable = 1'b0;
          if (ent.depth >= min_depth) begin
            case (ent.bound)
              BOUND_EXACT: usable = 1'b1;
              BOUND_UPPER: usable = (score <= int'(lo));
              BOUND_LOWER: usable = (score >= int'(hi));
              default:     usable = 1'b0;
            endcase
          end
          if (usable) begin
            rsp.value  = score[15:0];
            rsp.cutoff = 1'b1;
          end else begin
            rsp.move_hit  = 1'b1;
            rsp.hint_from = ent.mv_from;
            rsp.hint_dest = ent.mv_dest;
            rsp.hint_kind = ent.mv_kind;
          end
        end
      end
      OP_STORE: begin
        // pushed away from zero; the 16-bit field wraps
        score = int'(score_in);
        if (score >= int'(MATE_BOUND)) score = score + int'(plies);
        if (score <= int'(MATE_NEG)) score = score - int'(plies);
        ent.depth   = min_depth;
        ent.bound   = bkind;
        ent.value   = score[15:0];
        ent.mv_kind = mkind;
        ent.mv_dest = mdest;
        ent.mv_from = mfrom;
        shadow_tags[slot]    = key;
        shadow_entries[slot] = ent;
      end
      OP_CLEAR: begin
        shadow_tags.delete();
        shadow_entries.delete();
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic log_failure(input tt_response_t want, input tt_response_t got,
                             input bit unexpected);
    if (fails < 10) begin
      if (unexpected)
        $display("[%0t] unexpected result beat: value=%0d cut=%0b hit=%0b hint=%0d/%0d/%0d",
                 $realtime, got.value, got.cutoff, got.move_hit,
                 got.hint_from, got.hint_dest, got.hint_kind);
      else
        $display({"[%0t] mismatch: exp value=%0d cut=%0b hit=%0b hint=%0d/%0d/%0d",
                  " | got %0d %0b %0b %0d/%0d/%0d"},
                 $realtime, want.value, want.cutoff, want.move_hit,
                 want.hint_from, want.hint_dest, want.hint_kind,
                 got.value, got.cutoff, got.move_hit,
                 got.hint_from, got.hint_dest, got.hint_kind);
    end
    fails++;
  endtask

  always @(posedge clk) begin
    tt_response_t want;
    tt_response_t got;
    if (rst) begin
      shadow_tags.delete();
      shadow_entries.delete();
      expected_responses.delete();
    end else begin
      // result side first: a beat accepted this edge cannot be answered yet
      if (result_valid && result_ready) begin
        got.value     = value;
        got.cutoff    = cutoff;
        got.move_hit  = move_hit;
        got.hint_from = hint_from;
        got.hint_dest = hint_dest;
        got.hint_kind = hint_kind;
        if (expected_responses.size() == 0) begin
          log_failure('0, got, 1'b1);
        end else begin
          want = expected_responses.pop_front();
          if (got.value !== want.value || got.cutoff !== want.cutoff ||
              got.move_hit !== want.move_hit || got.hint_from !== want.hint_from ||
              got.hint_dest !== want.hint_dest || got.hint_kind !== want.hint_kind)
            log_failure(want, got, 1'b0);
        end
      end
      if (item_valid && item_ready)
        expected_responses.push_back(lookup_or_update(op, position_key, search_depth, ply,
                                                      alpha, beta, store_value, bound_kind,
                                                      move_from, move_dest, move_kind));
    end
    outstanding <= expected_responses.size();
    fail_count  <= fails;
  end

endmodule

`default_nettype wire

// ===== dv/transposition_table_probe_store_tb.sv =====
`default_nettype none

// Top of the testbench: clock, reset, stimulus, receiver back-pressure and
// the verdict. All prediction and comparison lives in the checker.
module transposition_table_probe_store_tb import ttps_pkg::*;;

  // op code 3 has no meaning; the block must answer zeros and keep its table
  localparam logic [1:0] OP_UNDEF    = 2'd3;
  localparam int         CYCLE_LIMIT = 2_000_000;
  localparam int         RANDOM_BEATS = 1425;
  localparam int         HOLD_SPACING = 500;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic [1:0]          op = OP_PROBE;
  logic [KEY_BITS-1:0] position_key = '0;
  logic [7:0]          search_depth = '0;
  logic [7:0]          ply = '0;
  logic signed [15:0]  alpha = '0;
  logic signed [15:0]  beta = '0;
  logic signed [15:0]  store_value = '0;
  logic [1:0]          bound_kind = BOUND_EXACT;
  logic [5:0]          move_from = '0;
  logic [5:0]          move_dest = '0;
  logic [3:0]          move_kind = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic signed [15:0]  value;
  logic                cutoff;
  logic                move_hit;
  logic [5:0]          hint_from;
  logic [5:0]          hint_dest;
  logic [3:0]          hint_kind;
  int                  fail_count;
  int                  outstanding;

  int                  beats_sent = 0;
  int                  burst_left = 0;
  int                  cycle_count = 0;

  // receiver state
  logic [7:0]          ready_mask = 8'hFF;
  logic [2:0]          mask_phase = '0;
  int                  hold_left = 0;
  int                  holds_done = 0;

  // keys recently stored, with the score they were stored with;
  // probes aim at these so that most of them reach the bound tests
  logic [KEY_BITS-1:0] key_pool[$];
  int                  score_pool[$];

  transposition_table_probe_store i_dut (.*);

  transposition_table_probe_store_checker i_checker (.*);

  always #2 clk = ~clk;

  // Hard stop. The slowest legal run is the power-on clear, at most five
  // full clears, two hold-offs and ~1450 beats with gaps and stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: an 8-bit ready pattern, played out bit by bit and redrawn after
  // its last bit, sometimes solid high. Twice in the run it holds off for a
  // long stretch while the sender keeps offering, so the queue and the result
  // register fill and item_ready has to drop.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (holds_done < 2 && beats_sent >= HOLD_SPACING * (holds_done + 1)) begin
      hold_left    <= 300;
      holds_done   <= holds_done + 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ready_mask[mask_phase];
      mask_phase   <= mask_phase + 3'd1;
      if (mask_phase == 3'd7) begin
        case ($urandom_range(0, 3))
          0:       ready_mask <= 8'hFF;
          1:       ready_mask <= 8'($urandom) | 8'h01;
          2:       ready_mask <= 8'($urandom) | 8'h11;
          default: ready_mask <= 8'h81;
        endcase
      end
    end
  end

  // Sender pacing: bursts of 1..40 beats, idle gaps between them, and now and
  // then no gap at all.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // One beat: payload and valid go up together and stay until accepted.
  task automatic drive_beat(
    input logic [1:0]          cmd,
    input logic [KEY_BITS-1:0] key,
    input logic [7:0]          dep,
    input logic [7:0]          plies,
    input logic signed [15:0]  lo,
    input logic signed [15:0]  hi,
    input logic signed [15:0]  score,
    input logic [1:0]          bkind,
    input logic [5:0]          mfrom,
    input logic [5:0]          mdest,
    input logic [3:0]          mkind
  );
    pace_sender();
    item_valid   <= 1'b1;
    op           <= cmd;
    position_key <= key;
    search_depth <= dep;
    ply          <= plies;
    alpha        <= lo;
    beta         <= hi;
    store_value  <= score;
    bound_kind   <= bkind;
    move_from    <= mfrom;
    move_dest    <= mdest;
    move_kind    <= mkind;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Fields a probe ignores still get random values so every bit toggles.
  task automatic probe_beat(input logic [KEY_BITS-1:0] key, input logic [7:0] dep,
                            input logic [7:0] plies, input logic signed [15:0] lo,
                            input logic signed [15:0] hi);
    drive_beat(OP_PROBE, key, dep, plies, lo, hi, 16'($urandom), 2'($urandom),
               6'($urandom), 6'($urandom), 4'($urandom));
  endtask

  task automatic store_beat(input logic [KEY_BITS-1:0] key, input logic [7:0] dep,
                            input logic [7:0] plies, input logic signed [15:0] score,
                            input logic [1:0] bkind, input logic [5:0] mfrom,
                            input logic [5:0] mdest, input logic [3:0] mkind);
    drive_beat(OP_STORE, key, dep, plies, 16'($urandom), 16'($urandom), score, bkind,
               mfrom, mdest, mkind);
  endtask

  // Scores: anything, just around the mate threshold, at the 16-bit rails
  // (where the store adjustment wraps), or small.
  function automatic logic signed [15:0] pick_score();
    int mag;
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: mag = int'($signed(16'($urandom)));
      1: mag = $urandom_range(9400, 9700);
      2: mag = $urandom_range(32500, 32767);
      default: mag = $urandom_range(0, 200);
    endcase
    if (pick != 0 && $urandom_range(0, 1) == 1) mag = -mag;
    if (pick == 2 && mag == -32767 && $urandom_range(0, 1) == 1) mag = -32768;
    return mag[15:0];
  endfunction

  // Window edge near a stored score, so upper/lower bound tests go both ways.
  function automatic logic signed [15:0] near_score(input int pivot);
    int edge_val;
    edge_val = pivot + $urandom_range(0, 600) - 300;
    if (edge_val > 32767) edge_val = 32767;
    if (edge_val < -32768) edge_val = -32768;
    return edge_val[15:0];
  endfunction

  initial begin
    logic [KEY_BITS-1:0] k1, k2, k3, k4, key;
    logic signed [15:0]  score, lo, hi;
    int                  roll, pick, clears_left;
    clears_left = 4;
    k1 = 64'hDEAD_BEEF_0000_1234;
    k2 = 64'h8000_0000_0000_00A5;
    k3 = 64'h7FFF_FFFF_FFFF_FF5A;
    k4 = 64'h0000_0001_0000_0077;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // key zero on a cleared slot matches: exact, depth 0, value 0
    probe_beat('0, 8'd0, 8'd0, 16'sd0, 16'sd0);
    // same, but asking for more depth: zero move hint
    probe_beat('0, 8'd1, 8'd77, 16'sd0, 16'sd0);
    // plain miss
    probe_beat('1, 8'd0, 8'd0, -16'sd32768, 16'sd32767);
    // mate score stored and probed with the largest ply
    store_beat(k1, 8'd10, 8'd200, 16'sd9600, BOUND_EXACT, 6'd63, 6'd63, 4'd15);
    probe_beat(k1, 8'd10, 8'd255, 16'sd0, 16'sd0);
    probe_beat(k1, 8'd11, 8'd0, 16'sd0, 16'sd0);
    // most negative score pushed down by 255 wraps to a large positive one
    store_beat(k2, 8'd255, 8'd255, -16'sd32768, BOUND_UPPER, 6'd0, 6'd0, 4'd0);
    probe_beat(k2, 8'd255, 8'd0, 16'sd32767, 16'sd0);
    probe_beat(k2, 8'd0, 8'd0, -16'sd32768, 16'sd0);
    // most positive score pushed up wraps negative; lower bound tests
    store_beat(k3, 8'd0, 8'd255, 16'sd32767, BOUND_LOWER, 6'd42, 6'd21, 4'd10);
    probe_beat(k3, 8'd0, 8'd1, 16'sd0, -16'sd32768);
    probe_beat(k3, 8'd0, 8'd1, 16'sd0, 16'sd32767);
    // bound kind three never cuts, even where a lower bound would (beta at its minimum)
    store_beat(k4, 8'd100, 8'd5, -16'sd9500, BOUND_NONE, 6'd1, 6'd2, 4'd3);
    probe_beat(k4, 8'd0, 8'd5, -16'sd32768, -16'sd32768);
    // same index, other tag: replaces k1, so k1 now misses
    store_beat({~k1[63], k1[62:0]}, 8'd50, 8'd0, 16'sd9499, BOUND_EXACT,
               6'd7, 6'd7, 4'd7);
    probe_beat(k1, 8'd0, 8'd0, 16'sd0, 16'sd0);
    // undefined op: zeros, table untouched
    drive_beat(OP_UNDEF, k4, 8'hFF, 8'hFF, 16'sh7FFF, -16'sd1, 16'sh5555, 2'd3,
               6'h3F, 6'h2A, 4'hF);
    probe_beat(k4, 8'd100, 8'd0, 16'sd0, 16'sd0);
    // clear, then the old entry is gone and key zero matches again
    drive_beat(OP_CLEAR, k4, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, BOUND_EXACT,
               6'd0, 6'd0, 4'd0);
    probe_beat(k4, 8'd0, 8'd0, 16'sd0, 16'sd0);
    probe_beat('0, 8'd0, 8'd0, 16'sd0, 16'sd0);
    store_beat(k3, 8'd5, 8'd9, 16'sd0, BOUND_EXACT, 6'd5, 6'd6, 4'd7);
    probe_beat(k3, 8'd5, 8'd9, 16'($urandom), 16'($urandom));

    // ---- random ----
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      roll = $urandom_range(0, 999);
      if (roll < 400 || key_pool.size() == 0) begin
        if (key_pool.size() > 0 && $urandom_range(0, 9) < 3)
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if ($urandom_range(0, 1) == 1)
          key = {$urandom, $urandom};
        else
          // crowd a few slots so tags collide
          key = {$urandom, $urandom} & ~64'(TABLE_DEPTH - 1) | 64'($urandom_range(0, 15));
        score = pick_score();
        store_beat(key, ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'($urandom_range(16, 255)),
                   8'($urandom), score, 2'($urandom), 6'($urandom), 6'($urandom),
                   4'($urandom));
        key_pool.push_back(key);
        score_pool.push_back(int'(score));
        if (key_pool.size() > 24) begin
          void'(key_pool.pop_front());
          void'(score_pool.pop_front());
        end
      end else if (roll < 960 || clears_left == 0 || (beats_sent % HOLD_SPACING) >= 400) begin
        pick = $urandom_range(0, key_pool.size() - 1);
        roll = $urandom_range(0, 99);
        if (roll < 65)      key = key_pool[pick];
        else if (roll < 75) key = key_pool[pick] ^ 64'(1 << $urandom_range(INDEX_BITS, 31));
        else if (roll < 85) key = '0;
        else                key = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 3) begin
          lo = 16'($urandom);
          hi = 16'($urandom);
        end else begin
          lo = near_score(score_pool[pick]);
          hi = near_score(score_pool[pick]);
        end
        probe_beat(key, ($urandom_range(0, 9) < 3) ? 8'($urandom) : 8'($urandom_range(0, 64)),
                   8'($urandom), lo, hi);
      end else if (roll < 996) begin
        drive_beat(OP_UNDEF, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
                   6'($urandom), 6'($urandom), 4'($urandom));
      end else begin
        // full clear walks the whole table: kept rare
        drive_beat(OP_CLEAR, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
                   6'($urandom), 6'($urandom), 4'($urandom));
        clears_left--;
        key_pool.delete();
        score_pool.delete();
      end
    end
    item_valid <= 1'b0;

    // drain: let the checker count take in the last beat, then wait for every
    // response plus a margin for strays
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
